FILE: rtl/segment_cube_face_crossing_defines.svh
// Assertion macros shared by the segment/cell face crossing RTL.
`ifndef SEGMENT_CUBE_FACE_CROSSING_DEFINES_SVH
`define SEGMENT_CUBE_FACE_CROSSING_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SCF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/scf_pkg.sv
// Types and constants of the segment/cell face crossing block.
`default_nettype none

package scf_pkg;

    localparam int COORD_BITS = 32;
    localparam int WIDTH_BITS = COORD_BITS - 1;
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int REM_BITS   = MAG_BITS + 1;
    localparam int T_FRAC     = 30;
    localparam int TQ_BITS    = T_FRAC + 1;
    localparam int HI_BITS    = MAG_BITS - T_FRAC;
    localparam int PLO_BITS   = TQ_BITS + T_FRAC;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int NUM_AXES   = 3;
    localparam int NUM_OTHER  = NUM_AXES - 1;
    localparam int AXIS_BITS  = 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [MAG_BITS-1:0] t_mag;

    typedef enum logic [AXIS_BITS-1:0] {
        FACE_X = 2'd0,
        FACE_Y = 2'd1,
        FACE_Z = 2'd2
    } t_face;

    typedef struct packed {
        t_coord                start_x;
        t_coord                start_y;
        t_coord                start_z;
        t_coord                end_x;
        t_coord                end_y;
        t_coord                end_z;
        t_coord                corner_x;
        t_coord                corner_y;
        t_coord                corner_z;
        logic [WIDTH_BITS-1:0] cell_width;
    } t_item;

    typedef struct packed {
        logic [AXIS_BITS-1:0] face;
        t_coord               hit_x;
        t_coord               hit_y;
        t_coord               hit_z;
        logic                 last_hit;
    } t_result;

    typedef struct packed {
        t_coord [NUM_AXES-1:0] p;
        t_coord [NUM_AXES-1:0] e;
        t_coord [NUM_AXES-1:0] c;
        logic [WIDTH_BITS-1:0] w;
    } t_geom;

    typedef struct packed {
        t_geom                geom;
        t_mag [NUM_AXES-1:0]  magd;
        logic [NUM_AXES-1:0]  dneg;
        logic [NUM_AXES-1:0]  cand;
        logic [NUM_AXES-1:0]  full;
    } t_side;

    typedef struct packed {
        logic [NUM_AXES-1:0]                   hits;
        t_coord [NUM_AXES-1:0][NUM_AXES-1:0]   pts;
    } t_hitset;

endpackage

`default_nettype wire

FILE: rtl/segment_cube_face_crossing.sv
// Top level of the segment versus cube-cell lower-face crossing block.
`default_nettype none

// Tests one segment against the three lower faces of one cube cell per item,
// in the order x, y, z, in signed Q16.16. Drive an item on i_item with start
// high; it is taken at a rising edge where busy is low. Each crossing comes
// out for one cycle with o_result_valid high; the last crossing of an item
// carries last_hit. An item with no crossing gives no result at all, so
// count on last_hit, not on results per item. The receiver cannot stall:
// take every result in the cycle it appears.
// Rate: one item per cycle while items have at most one crossing. An item
// with several crossings sends them on the result port one after another,
// since the port sends one crossing per cycle, and so holds the input; busy
// is high while a held item still has more than one crossing left to send.
// An item's first result appears after it has passed two delta/range
// stages, 30 divider stages (one bit of t each), three scale and bounds
// stages, the crossing register and the result register. The whole
// pipeline advances together and holds together, so nothing is lost or sent
// twice while busy is high.
module segment_cube_face_crossing
    import scf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_item   i_item,
    output logic         busy,
    output logic         o_result_valid,
    output t_result      o_result
);

    logic                             w_stall;
    logic                             w_en;
    logic                             w_take;

    logic                             w_fr_vld;
    t_side                            w_fr_side;
    t_mag [NUM_AXES-1:0]              w_fr_magn;

    logic                             w_dv_vld;
    t_side                            w_dv_side;
    logic [NUM_AXES-1:0][TQ_BITS-1:0] w_dv_tq;

    logic                             w_sc_vld;
    t_hitset                          w_sc_hitset;

    // Advance every stage together unless the sequencer holds extra crossings.
    assign w_en   = !w_stall;
    assign busy   = w_stall;
    assign w_take = start && !busy;

    scf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_take),
        .i_item  (i_item),
        .o_valid (w_fr_vld),
        .o_side  (w_fr_side),
        .o_magn  (w_fr_magn)
    );

    // t = |n| / |d| with 30 fractional bits.
    scf_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_vld),
        .i_side  (w_fr_side),
        .i_magn  (w_fr_magn),
        .o_valid (w_dv_vld),
        .o_side  (w_dv_side),
        .o_tq    (w_dv_tq)
    );

    // Hit points and inclusive face bounds.
    scf_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_dv_vld),
        .i_side   (w_dv_side),
        .i_tq     (w_dv_tq),
        .o_valid  (w_sc_vld),
        .o_hitset (w_sc_hitset)
    );

    scf_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_sc_vld),
        .i_hitset       (w_sc_hitset),
        .o_stall        (w_stall),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

FILE: rtl/scf_front.sv
// Front stages: axis deltas, magnitudes and the exact range test on t.
`default_nettype none

module scf_front
    import scf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire t_item                         i_item,
    output logic                               o_valid,
    output t_side                              o_side,
    output t_mag [NUM_AXES-1:0]                o_magn
);

    t_geom w_geom;
    logic signed [MAG_BITS-1:0] w_d [NUM_AXES];
    logic signed [MAG_BITS-1:0] w_n [NUM_AXES];

    logic                       r1_vld;
    t_geom                      r1_geom;
    logic signed [MAG_BITS-1:0] r1_d [NUM_AXES];
    logic signed [MAG_BITS-1:0] r1_n [NUM_AXES];

    t_side               n_side;
    t_mag [NUM_AXES-1:0] n_magn;
    logic                r2_vld;
    t_side               r2_side;
    t_mag [NUM_AXES-1:0] r2_magn;

    always_comb begin
        w_geom.p[0] = i_item.start_x;
        w_geom.p[1] = i_item.start_y;
        w_geom.p[2] = i_item.start_z;
        w_geom.e[0] = i_item.end_x;
        w_geom.e[1] = i_item.end_y;
        w_geom.e[2] = i_item.end_z;
        w_geom.c[0] = i_item.corner_x;
        w_geom.c[1] = i_item.corner_y;
        w_geom.c[2] = i_item.corner_z;
        w_geom.w    = i_item.cell_width;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_d[a] = MAG_BITS'($signed(w_geom.e[a])) - MAG_BITS'($signed(w_geom.p[a]));
            w_n[a] = MAG_BITS'($signed(w_geom.c[a])) - MAG_BITS'($signed(w_geom.p[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_geom <= w_geom;
            r1_d    <= w_d;
            r1_n    <= w_n;
        end
    end

    // t in 0..1 exactly: d nonzero, and n zero or same sign as d with |n| <= |d|.
    always_comb begin
        n_side.geom = r1_geom;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_magn[a]      = r1_n[a][MAG_BITS-1] ? t_mag'(-r1_n[a]) : t_mag'(r1_n[a]);
            n_side.magd[a] = r1_d[a][MAG_BITS-1] ? t_mag'(-r1_d[a]) : t_mag'(r1_d[a]);
            n_side.dneg[a] = r1_d[a][MAG_BITS-1];
            n_side.full[a] = n_magn[a] >= n_side.magd[a];
            n_side.cand[a] = (r1_d[a] != '0) &&
                             ((r1_n[a] == '0) ||
                              ((r1_n[a][MAG_BITS-1] == r1_d[a][MAG_BITS-1]) &&
                               (n_magn[a] <= n_side.magd[a])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= n_side;
            r2_magn <= n_magn;
        end
    end

    assign o_valid = r2_vld;
    assign o_side  = r2_side;
    assign o_magn  = r2_magn;

endmodule

`default_nettype wire

FILE: rtl/scf_divider.sv
// Restoring divider pipeline: one quotient bit per stage for all three axes.
`default_nettype none

module scf_divider
    import scf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire t_side                         i_side,
    input  wire t_mag [NUM_AXES-1:0]           i_magn,
    output logic                               o_valid,
    output t_side                              o_side,
    output logic [NUM_AXES-1:0][TQ_BITS-1:0]   o_tq
);

    logic                                r_vld  [T_FRAC];
    t_side                               r_side [T_FRAC];
    logic [NUM_AXES-1:0][REM_BITS-1:0]   r_rem  [T_FRAC];
    logic [NUM_AXES-1:0][T_FRAC-1:0]     r_quo  [T_FRAC];

    for (genvar s = 0; s < T_FRAC; s++) begin : g_stage
        logic                              in_vld;
        t_side                             in_side;
        logic [NUM_AXES-1:0][REM_BITS-1:0] in_rem;
        logic [NUM_AXES-1:0][T_FRAC-1:0]   in_quo;
        logic [NUM_AXES-1:0][REM_BITS-1:0] nx_rem;
        logic [NUM_AXES-1:0][T_FRAC-1:0]   nx_quo;

        if (s == 0) begin : g_head
            always_comb begin
                in_vld  = i_valid;
                in_side = i_side;
                in_quo  = '0;
                for (int a = 0; a < NUM_AXES; a++) begin
                    in_rem[a] = REM_BITS'(i_magn[a]);
                end
            end
        end else begin : g_body
            always_comb begin
                in_vld  = r_vld[s-1];
                in_side = r_side[s-1];
                in_rem  = r_rem[s-1];
                in_quo  = r_quo[s-1];
            end
        end

        // Shift in a zero, subtract the divisor where it fits.
        always_comb begin
            logic [REM_BITS-1:0] sh;
            logic [REM_BITS-1:0] dv;
            for (int a = 0; a < NUM_AXES; a++) begin
                sh = {in_rem[a][REM_BITS-2:0], 1'b0};
                dv = REM_BITS'(in_side.magd[a]);
                if (sh >= dv) begin
                    nx_rem[a] = sh - dv;
                    nx_quo[a] = {in_quo[a][T_FRAC-2:0], 1'b1};
                end else begin
                    nx_rem[a] = sh;
                    nx_quo[a] = {in_quo[a][T_FRAC-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= in_side;
                r_rem[s]  <= nx_rem;
                r_quo[s]  <= nx_quo;
            end
        end
    end

    // |n| == |d| gives exactly one.
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            o_tq[a] = r_side[T_FRAC-1].full[a] ? (TQ_BITS'(1) << T_FRAC)
                                               : {1'b0, r_quo[T_FRAC-1][a]};
        end
    end

    assign o_valid = r_vld[T_FRAC-1];
    assign o_side  = r_side[T_FRAC-1];

endmodule

`default_nettype wire

FILE: rtl/scf_scale.sv
// Hit point stages: scale the other axes by t, add the start, test the face bounds.
`default_nettype none

module scf_scale
    import scf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire t_side                         i_side,
    input  wire logic [NUM_AXES-1:0][TQ_BITS-1:0] i_tq,
    output logic                               o_valid,
    output t_hitset                            o_hitset
);

    logic                 r3_vld;
    t_side                r3_side;
    logic [PLO_BITS-1:0]  r3_plo [NUM_AXES][NUM_OTHER];
    logic [SUM_BITS-1:0]  r3_phi [NUM_AXES][NUM_OTHER];

    logic                 r4_vld;
    t_side                r4_side;
    t_coord               r4_h   [NUM_AXES][NUM_OTHER];

    logic                 w_ok   [NUM_AXES][NUM_OTHER];
    t_coord               w_pts  [NUM_AXES][NUM_AXES];
    t_hitset              n_hitset;

    logic                 r5_vld;
    t_hitset              r5_hitset;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        for (genvar k = 0; k < NUM_OTHER; k++) begin : g_other
            localparam int B = (a + k + 1) % NUM_AXES;

            logic [SUM_BITS-1:0]        q;
            logic                       frac_nz;
            logic signed [SUM_BITS-1:0] off;
            logic signed [SUM_BITS-1:0] h;
            logic signed [SUM_BITS-1:0] lo_b;
            logic signed [SUM_BITS-1:0] hi_b;

            // Split |d| into high and low parts around the t binary point.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r3_plo[a][k] <= PLO_BITS'(i_tq[a]) *
                                    PLO_BITS'(i_side.magd[B][T_FRAC-1:0]);
                    r3_phi[a][k] <= SUM_BITS'(i_tq[a]) *
                                    SUM_BITS'(i_side.magd[B][MAG_BITS-1:T_FRAC]);
                end
            end

            // Floor toward minus infinity on a negative delta.
            always_comb begin
                q       = r3_phi[a][k] + SUM_BITS'(r3_plo[a][k][PLO_BITS-1:T_FRAC]);
                frac_nz = r3_plo[a][k][T_FRAC-1:0] != '0;
                off     = r3_side.dneg[B] ? -$signed(q + SUM_BITS'(frac_nz)) : $signed(q);
                h       = SUM_BITS'($signed(r3_side.geom.p[B])) + off;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r4_h[a][k] <= h[COORD_BITS-1:0];
                end
            end

            always_comb begin
                lo_b = SUM_BITS'($signed(r4_side.geom.c[B]));
                hi_b = lo_b + $signed(SUM_BITS'(r4_side.geom.w));
                w_ok[a][k] = (SUM_BITS'($signed(r4_h[a][k])) >= lo_b) &&
                             (SUM_BITS'($signed(r4_h[a][k])) <= hi_b);
            end

            assign w_pts[a][B] = r4_h[a][k];
        end

        assign w_pts[a][a] = r4_side.geom.c[a];
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_hitset.hits[a] = r4_side.cand[a] && w_ok[a][0] && w_ok[a][1];
            for (int b = 0; b < NUM_AXES; b++) begin
                n_hitset.pts[a][b] = w_pts[a][b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= i_valid;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side   <= i_side;
            r4_side   <= r3_side;
            r5_hitset <= n_hitset;
        end
    end

    assign o_valid  = r5_vld;
    assign o_hitset = r5_hitset;

endmodule

`default_nettype wire

FILE: rtl/scf_emit.sv
// Result sequencer: sends one crossing per cycle and holds the pipeline on extras.
`default_nettype none

`include "segment_cube_face_crossing_defines.svh"

module scf_emit
    import scf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_hitset   i_hitset,
    output logic           o_stall,
    output logic           o_result_valid,
    output t_result        o_result
);

    logic [NUM_AXES-1:0]                 r_mask;
    t_coord [NUM_AXES-1:0][NUM_AXES-1:0] r_pts;
    logic                                r_strobe;
    t_result                             r_res;

    logic [NUM_AXES-1:0] n_mask;
    logic [NUM_AXES-1:0] w_rest;
    logic                n_strobe;
    t_result             n_res;

    // Two or more crossings pending: the next item must wait.
    assign o_stall = (r_mask & (r_mask - NUM_AXES'(1))) != '0;

    always_comb begin
        n_res    = r_res;
        n_strobe = r_mask != '0;
        w_rest   = r_mask;
        priority if (r_mask[0]) begin
            n_res.face  = FACE_X;
            n_res.hit_x = r_pts[0][0];
            n_res.hit_y = r_pts[0][1];
            n_res.hit_z = r_pts[0][2];
            w_rest[0]   = 1'b0;
        end else if (r_mask[1]) begin
            n_res.face  = FACE_Y;
            n_res.hit_x = r_pts[1][0];
            n_res.hit_y = r_pts[1][1];
            n_res.hit_z = r_pts[1][2];
            w_rest[1]   = 1'b0;
        end else if (r_mask[2]) begin
            n_res.face  = FACE_Z;
            n_res.hit_x = r_pts[2][0];
            n_res.hit_y = r_pts[2][1];
            n_res.hit_z = r_pts[2][2];
            w_rest[2]   = 1'b0;
        end else begin
            n_res.face  = FACE_X;
        end
        n_res.last_hit = w_rest == '0;

        if (o_stall) begin
            n_mask = w_rest;
        end else if (i_valid) begin
            n_mask = i_hitset.hits;
        end else begin
            n_mask = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_mask   <= n_mask;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!o_stall && i_valid) begin
            r_pts <= i_hitset.pts;
        end
    end

    assign o_result_valid = r_strobe;
    assign o_result       = r_res;

    `SCF_ASSERT_NXT(a_stall_sends_more, i_clk, i_rst_n, o_stall, o_result_valid && !o_result.last_hit, "held item gave no result or ended early")
    `SCF_ASSERT_IMP(a_not_last_pending, i_clk, i_rst_n, o_result_valid && !o_result.last_hit, r_mask != '0, "crossing marked not last but none pending")
    `SCF_ASSERT_NXT(a_empty_quiet, i_clk, i_rst_n, r_mask == '0, !o_result_valid, "result sent with nothing pending")

endmodule

`default_nettype wire
